### hw/rtl/wfs_pkg.sv
`default_nettype none

package wfs_pkg;

  localparam int HashW   = 64;
  localparam int PosW    = 32;
  localparam int CfgW    = 5;
  localparam logic [CfgW-1:0] CfgWinReset = CfgW'(5);

  // One prefix-minimum entry: the smallest hash among the newest k+1 hashes
  // and the document position it came from.
  typedef struct packed {
    logic signed [HashW-1:0] value;
    logic [PosW-1:0]         pos;
  } entry_t;

endpackage

`default_nettype wire

### hw/rtl/wfs_cell.sv
`default_nettype none

// One link of the prefix-minimum chain. On each transaction the cell takes
// the smaller of the incoming hash and its neighbor's previous minimum; on a
// tie the neighbor's entry is older and wins.
module wfs_cell (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire wfs_pkg::entry_t new_i,
  input  wire wfs_pkg::entry_t prev_i,
  output wfs_pkg::entry_t      pm_o
);

  wfs_pkg::entry_t pm_q;
  wfs_pkg::entry_t pm_d;

  always_comb begin
    pm_d = (new_i.value < prev_i.value) ? new_i : prev_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pm_q <= pm_d;
    end
  end

  assign pm_o = pm_q;

endmodule

`default_nettype wire

### hw/rtl/winnowing_fingerprint_selector_unit.sv
`default_nettype none
// A fingerprint is registered when its hash is accepted, into the output register or the skid.
// Throughput: one hash per cycle while ready is high; each chain cell compares once per transaction.
// A two-entry output buffer (output register plus skid) lets hashes keep flowing
// while one fingerprint waits; ready drops only when both entries are full.
// Reset clears the window size to 5, positions, fill count and the output buffer;
// the chain cells hold no reset and need no clearing pass.

module winnowing_fingerprint_selector_unit #(
  parameter int MAX_WINDOW = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [wfs_pkg::CfgW-1:0]        cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic signed [wfs_pkg::HashW-1:0] hash_value_i,
  input  wire logic                            doc_start_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic signed [wfs_pkg::HashW-1:0]     fingerprint_o
);

  localparam int CntW = $clog2(MAX_WINDOW + 1);
  localparam int IdxW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  logic [wfs_pkg::CfgW-1:0] win_cfg_q;
  logic [CntW-1:0]          fill_q, fill_d, fill_new;
  logic [wfs_pkg::PosW-1:0] pos_cnt_q, pos_cnt_d, pos_new;
  logic [wfs_pkg::PosW-1:0] last_min_q, last_min_d;
  logic                     emitted_q, emitted_d, emitted_cur;
  logic [CntW-1:0]          win_eff;
  logic [IdxW-1:0]          sel_idx;
  logic                     in_acc, out_take, emit;

  wfs_pkg::entry_t new_ent, prev_ent, cand;
  wfs_pkg::entry_t pm [MAX_WINDOW];

  wfs_pkg::entry_t out_q, out_d, skid_q, skid_d;
  logic            out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;

  assign in_ready_o    = !skid_valid_q;
  assign in_acc        = in_valid_i && in_ready_o;
  assign out_take      = out_valid_q && out_ready_i;
  assign out_valid_o   = out_valid_q;
  assign fingerprint_o = out_q.value;

  // Clamp window size into 1..MAX_WINDOW.
  always_comb begin
    if (win_cfg_q == '0) begin
      win_eff = CntW'(1);
    end else if (32'(win_cfg_q) > MAX_WINDOW) begin
      win_eff = CntW'(MAX_WINDOW);
    end else begin
      win_eff = CntW'(win_cfg_q);
    end
  end

  assign pos_new     = doc_start_i ? '0 : pos_cnt_q;
  assign emitted_cur = doc_start_i ? 1'b0 : emitted_q;

  always_comb begin
    if (doc_start_i) begin
      fill_new = CntW'(1);
    end else if (fill_q == CntW'(MAX_WINDOW)) begin
      fill_new = fill_q;
    end else begin
      fill_new = fill_q + CntW'(1);
    end
  end

  assign new_ent.value = hash_value_i;
  assign new_ent.pos   = pos_new;

  // Chain of prefix-minimum cells: cell k covers the newest k+1 hashes.
  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    if (k == 0) begin : g_head
      wfs_cell u_cell (
        .clk_i  (clk_i),
        .en_i   (in_acc),
        .new_i  (new_ent),
        .prev_i (new_ent),
        .pm_o   (pm[k])
      );
    end else begin : g_link
      wfs_cell u_cell (
        .clk_i  (clk_i),
        .en_i   (in_acc),
        .new_i  (new_ent),
        .prev_i (pm[k-1]),
        .pm_o   (pm[k])
      );
    end
  end

  // Window minimum after this shift equals cell (w-1)'s next value.
  assign sel_idx  = IdxW'(win_eff - CntW'(2));
  assign prev_ent = pm[sel_idx];

  always_comb begin
    if (win_eff == CntW'(1)) begin
      cand = new_ent;
    end else begin
      cand = (new_ent.value < prev_ent.value) ? new_ent : prev_ent;
    end
  end

  assign emit = in_acc && (fill_new >= win_eff) &&
                !(emitted_cur && (cand.pos == last_min_q));

  always_comb begin
    fill_d     = fill_q;
    pos_cnt_d  = pos_cnt_q;
    emitted_d  = emitted_q;
    last_min_d = last_min_q;
    if (in_acc) begin
      fill_d    = fill_new;
      pos_cnt_d = pos_new + wfs_pkg::PosW'(1);
      emitted_d = emitted_cur;
    end
    if (emit) begin
      emitted_d  = 1'b1;
      last_min_d = cand.pos;
    end
  end

  // Output register with skid: drain skid first, then place a new fingerprint.
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q && !out_take;
    skid_valid_d = skid_valid_q;
    if (!out_valid_d && skid_valid_q) begin
      out_d        = skid_q;
      out_valid_d  = 1'b1;
      skid_valid_d = 1'b0;
    end
    if (emit) begin
      if (!out_valid_d) begin
        out_d       = cand;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = cand;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_cfg_q    <= wfs_pkg::CfgWinReset;
      fill_q       <= '0;
      pos_cnt_q    <= '0;
      last_min_q   <= '0;
      emitted_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        win_cfg_q <= cfg_wdata_i;
      end
      fill_q       <= fill_d;
      pos_cnt_q    <= pos_cnt_d;
      last_min_q   <= last_min_d;
      emitted_q    <= emitted_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

`default_nettype wire

### hw/rtl/wfs_checker.sv
`default_nettype none

module wfs_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             in_ready_o,
  input wire logic                             out_valid_o,
  input wire logic                             out_ready_i,
  input wire logic signed [wfs_pkg::HashW-1:0] fingerprint_o
);

  // Stalled output transaction holds its fingerprint.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(fingerprint_o)))
    else $error("stalled fingerprint changed or dropped");

  // Input backpressure only comes from a full output buffer.
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // Draining the output frees the skid entry on the next cycle.
  a_ready_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_ready_o && out_ready_i) |=> in_ready_o)
    else $error("input stayed stalled after output drained");

  // Once reset has been seen at an edge, no fingerprint is presented.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> (!out_valid_o && in_ready_o))
    else $error("output active during reset");

endmodule

bind winnowing_fingerprint_selector_unit wfs_checker u_wfs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .fingerprint_o (fingerprint_o)
);

`default_nettype wire
